// ===== sv/sse_pkg.sv =====
// Shared types, constants and a helper function for the sorted set engine.
package sse_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int COUNT_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_FROM_LEFT,
        OP_FROM_RIGHT
    } t_cell_op;

    typedef struct packed {
        logic match;
        logic precedes;
    } t_cell_flags;

    // Inclusive prefix OR, built as a log-depth network over the cells.
    function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] x);
        logic [CAPACITY-1:0] acc;
        acc = x;
        for (int l = 0; (1 << l) < CAPACITY; l++) begin
            for (int i = CAPACITY - 1; i >= 0; i--) begin
                if (i >= (1 << l)) begin
                    acc[i] = acc[i] | acc[i - (1 << l)];
                end
            end
        end
        return acc;
    endfunction

endpackage

// ===== sv/sse_cell.sv =====
// One storage cell of the sorted set chain: holds a value and compares it with the key.
module sse_cell (
    input  logic                                  i_clk,
    input  logic                                  i_cmp_en,
    input  logic                                  i_order,
    input  logic signed [sse_pkg::VALUE_W-1:0]    i_key,
    input  sse_pkg::t_cell_op                     i_op,
    input  logic signed [sse_pkg::VALUE_W-1:0]    i_left,
    input  logic signed [sse_pkg::VALUE_W-1:0]    i_right,
    output logic signed [sse_pkg::VALUE_W-1:0]    o_data,
    output sse_pkg::t_cell_flags                  o_flags
);

    logic signed [sse_pkg::VALUE_W-1:0] r_data;
    sse_pkg::t_cell_flags               r_flags;

    // The flags say whether the key equals the held value and whether the key
    // belongs strictly ahead of it in the selected order.
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_flags.match    <= (i_key == r_data);
            r_flags.precedes <= i_order ? (i_key > r_data) : (i_key < r_data);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            sse_pkg::OP_HOLD:       r_data <= r_data;
            sse_pkg::OP_LOAD:       r_data <= i_key;
            sse_pkg::OP_FROM_LEFT:  r_data <= i_left;
            sse_pkg::OP_FROM_RIGHT: r_data <= i_right;
            default:                r_data <= r_data;
        endcase
    end

    assign o_data  = r_data;
    assign o_flags = r_flags;

endmodule

// ===== sv/sorted_set_engine_core.sv =====
// Top level of the sorted set engine: request control and the chain of value cells.
//
//  Channel   | Handshake            | Payload
//  ----------+----------------------+-----------------------------------------
//  request   | start, busy          | i_func, i_value
//  result    | o_done (one cycle)   | o_success, o_count, o_full_refused
//  config    | i_cfg_wen            | i_cfg_wdata (order_mode)
//
// Every item is accepted, then all cells compare the key with their values
// in parallel, then the cells shift, load or hold.
// The result appears on o_done in the cycle after the update, while the
// next item may already be accepted. The receiver cannot stall the block.
// Reset (i_rst_n low at a clock edge) empties the store and selects
// ascending order; the stored values themselves are not cleared.
module sorted_set_engine_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sse_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [sse_pkg::VALUE_W-1:0]  i_value,
    input  logic                                i_cfg_wen,
    input  logic                                i_cfg_wdata,
    output logic                                o_done,
    output logic                                o_success,
    output logic [sse_pkg::COUNT_W-1:0]         o_count,
    output logic                                o_full_refused
);

    localparam int CAP = sse_pkg::CAPACITY;
    localparam int CW  = sse_pkg::CNT_W;
    localparam int VW  = sse_pkg::VALUE_W;

    sse_pkg::t_state r_state;
    sse_pkg::t_state n_state;

    logic                        r_order;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic [sse_pkg::FUNC_W-1:0]  r_func;
    logic signed [VW-1:0]        r_key;

    logic                        r_done;
    logic                        r_success;
    logic                        r_full;
    logic                        n_success;
    logic                        n_full;

    logic                        accept;
    logic                        cmp_en;
    logic                        upd_en;

    logic signed [VW-1:0]        cell_data  [CAP];
    sse_pkg::t_cell_flags        cell_flags [CAP];
    sse_pkg::t_cell_op           cell_op    [CAP];

    logic [CAP-1:0]              occ;
    logic [CAP-1:0]              at_end;
    logic [CAP-1:0]              hit;
    logic [CAP-1:0]              ahead;
    logic [CAP-1:0]              ahead_incl;
    logic [CAP-1:0]              hit_incl;
    logic                        any_hit;
    logic                        any_ahead;
    logic                        is_full;
    logic                        do_add;
    logic                        do_remove;

    assign accept = start && !busy;

    // Sequencer: next state.
    always_comb begin
        case (r_state)
            sse_pkg::ST_IDLE:    n_state = accept ? sse_pkg::ST_COMPARE : sse_pkg::ST_IDLE;
            sse_pkg::ST_COMPARE: n_state = sse_pkg::ST_UPDATE;
            sse_pkg::ST_UPDATE:  n_state = sse_pkg::ST_IDLE;
            default:             n_state = sse_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        case (r_state)
            sse_pkg::ST_IDLE: begin
                busy   = 1'b0;
                cmp_en = 1'b0;
                upd_en = 1'b0;
            end
            sse_pkg::ST_COMPARE: begin
                busy   = 1'b1;
                cmp_en = 1'b1;
                upd_en = 1'b0;
            end
            sse_pkg::ST_UPDATE: begin
                busy   = 1'b1;
                cmp_en = 1'b0;
                upd_en = 1'b1;
            end
            default: begin
                busy   = 1'b0;
                cmp_en = 1'b0;
                upd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sse_pkg::ST_IDLE;
            r_order <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                r_order <= i_cfg_wdata;
            end
            r_count <= n_count;
            r_done  <= upd_en;
        end
    end

    // The request is captured on acceptance and held through the compare and update states.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_key  <= i_value;
        end
        if (upd_en) begin
            r_success <= n_success;
            r_full    <= n_full;
        end
    end

    // A cell is occupied when its position lies below the fill count, so
    // flags of empty cells are masked off here rather than in the cells.
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            occ[i]    = CW'(i) < r_count;
            at_end[i] = CW'(i) == r_count;
            hit[i]    = cell_flags[i].match && occ[i];
            ahead[i]  = cell_flags[i].precedes && occ[i];
        end
    end

    assign ahead_incl = sse_pkg::prefix_or(ahead);
    assign hit_incl   = sse_pkg::prefix_or(hit);
    assign any_hit    = hit_incl[CAP-1];
    assign any_ahead  = ahead_incl[CAP-1];
    assign is_full    = r_count == CW'(CAP);

    // An add goes in front of the first entry that the order places after
    // the key, or at the end when there is none. Duplicates and a full
    // store refuse it. A remove closes the gap left by the matching entry.
    assign do_add    = (r_func == sse_pkg::FUNC_ADD) && !any_hit && !is_full;
    assign do_remove = (r_func == sse_pkg::FUNC_REMOVE) && any_hit;

    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            cell_op[i] = sse_pkg::OP_HOLD;
            if (upd_en) begin
                if (do_add) begin
                    if (i > 0 && ahead_incl[(i > 0) ? i - 1 : 0]) begin
                        cell_op[i] = sse_pkg::OP_FROM_LEFT;
                    end else if (ahead[i] || (!any_ahead && at_end[i])) begin
                        cell_op[i] = sse_pkg::OP_LOAD;
                    end
                end else if (do_remove && hit_incl[i]) begin
                    cell_op[i] = sse_pkg::OP_FROM_RIGHT;
                end
            end
        end
    end

    always_comb begin
        n_count   = r_count;
        n_success = 1'b0;
        n_full    = 1'b0;
        case (r_func)
            sse_pkg::FUNC_ADD: begin
                n_success = do_add;
                n_full    = !any_hit && is_full;
            end
            sse_pkg::FUNC_REMOVE: begin
                n_success = do_remove;
            end
            sse_pkg::FUNC_SEARCH: begin
                n_success = any_hit;
            end
            default: begin
                n_success = 1'b0;
            end
        endcase
        if (upd_en && do_add) begin
            n_count = r_count + CW'(1);
        end else if (upd_en && do_remove) begin
            n_count = r_count - CW'(1);
        end
    end

    // The cell row: each cell sees its neighbours' values for shifting. The
    // ends of the row take the key or their own value, which is never used.
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic signed [VW-1:0] left_data;
        logic signed [VW-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = r_key;
        end else begin : g_inner_l
            assign left_data = cell_data[g-1];
        end

        if (g == CAP - 1) begin : g_last
            assign right_data = cell_data[g];
        end else begin : g_inner_r
            assign right_data = cell_data[g+1];
        end

        sse_cell u_cell (
            .i_clk    (i_clk),
            .i_cmp_en (cmp_en),
            .i_order  (r_order),
            .i_key    (r_key),
            .i_op     (cell_op[g]),
            .i_left   (left_data),
            .i_right  (right_data),
            .o_data   (cell_data[g]),
            .o_flags  (cell_flags[g])
        );
    end

    // The count register already holds the value after the request when
    // the result is shown, and it does not move again before the next update.
    assign o_done         = r_done;
    assign o_success      = r_success;
    assign o_full_refused = r_full;
    assign o_count        = sse_pkg::COUNT_W'(r_count);

endmodule

// ===== sv/sse_checker.sv =====
// Port-level checker for the sorted set engine and its bind statement.
module sse_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_done,
    input logic                                o_success,
    input logic                                o_full_refused
);

    // An accepted item keeps the block busy through the compare and update states, then releases it.
    a_busy_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 busy ##1 !busy)
        else $error("busy span after acceptance is wrong");

    // Every result stems from an accepted item that has passed its compare and update states.
    a_done_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 3))
        else $error("result without a matching accepted item");

    // Each accepted item yields its result after its compare and update states, through the done register.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##2 o_done)
        else $error("accepted item produced no result");

    // A refusal for lack of room is never reported as a success.
    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_full_refused) |-> !o_success)
        else $error("full refusal flagged together with success");

endmodule

bind sorted_set_engine_core sse_checker u_sse_checker (.*);
